// ===== sv/scfbc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and the size class function of the free block cache.
// Used by every module of the block but scfbc_ram; depends on nothing.
package scfbc_pkg;

  localparam int NUM_CLASSES          = 11;
  localparam int SLOTS_PER_CLASS_DEF  = 32;
  localparam int ADDR_BITS_DEF        = 24;
  localparam int SIZE_W               = 24;
  localparam int REQ_W                = 25;
  localparam int CLASS_W              = 4;
  localparam int HIT_W                = 32;
  localparam int SEL_IDX_W            = 6;
  localparam int NUM_BOUNDS           = 10;

  typedef enum logic [1:0] {
    FN_GET   = 2'd0,
    FN_ADD   = 2'd1,
    FN_CLEAR = 2'd2,
    FN_RESET = 2'd3
  } func_t;

  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_t;

  typedef struct packed {
    logic                 found;
    logic [SEL_IDX_W-1:0] idx;
  } sel_t;

  localparam logic [REQ_W-1:0] CLASS_BOUND [NUM_BOUNDS] = '{
    25'd8, 25'd16, 25'd32, 25'd64, 25'd128,
    25'd256, 25'd512, 25'd1024, 25'd4096, 25'd8192
  };

  function automatic logic [CLASS_W-1:0] size_class(input logic [REQ_W-1:0] size);
    logic [CLASS_W-1:0] cls;
    cls = CLASS_W'(NUM_BOUNDS);
    for (int c = NUM_BOUNDS - 1; c >= 0; c--) begin
      if (size < CLASS_BOUND[c]) begin
        cls = CLASS_W'(c);
      end
    end
    return cls;
  endfunction

endpackage

// ===== sv/scfbc_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; holds the rows of the free block table.
module scfbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/scfbc_row_sel.sv =====
`timescale 1ns / 1ps
// Shared compare unit: tests every slot of one class row and picks the winner
// through a minimum tree, lowest slot on a tie. Depends on scfbc_pkg.
module scfbc_row_sel import scfbc_pkg::*; #(
  parameter int SLOTS     = SLOTS_PER_CLASS_DEF,
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  func_t                func,
  input  logic [SLOTS-1:0]     valid,
  input  logic [ADDR_BITS-1:0] slot_addr [SLOTS],
  input  logic [SIZE_W-1:0]    slot_size [SLOTS],
  input  logic [REQ_W-1:0]     req,
  input  logic [ADDR_BITS-1:0] addr,
  output sel_t                 sel
);

  localparam int LEVELS = (SLOTS > 1) ? $clog2(SLOTS) : 0;
  localparam int PAD    = 1 << LEVELS;

  logic [2*PAD-1:0]     n_found;
  logic [SIZE_W-1:0]    n_key [2*PAD];
  logic [SEL_IDX_W-1:0] n_idx [2*PAD];

  always_comb begin
    n_found = '0;
    for (int n = 0; n < 2 * PAD; n++) begin
      n_key[n] = '0;
      n_idx[n] = '0;
    end
    // Add and clear use a key of zero, so the tree returns the first match.
    for (int i = 0; i < SLOTS; i++) begin
      n_idx[PAD+i] = SEL_IDX_W'(i);
      unique case (func) inside
        FN_GET: begin
          n_found[PAD+i] = valid[i] && ({1'b0, slot_size[i]} >= req);
          n_key[PAD+i]   = slot_size[i];
        end
        FN_ADD: begin
          n_found[PAD+i] = !valid[i] || (slot_size[i] < req[SIZE_W-1:0]);
        end
        FN_CLEAR: begin
          n_found[PAD+i] = valid[i] && (slot_addr[i] == addr);
        end
        default: begin
          n_found[PAD+i] = 1'b0;
        end
      endcase
    end
    for (int n = PAD - 1; n >= 1; n--) begin
      n_found[n] = n_found[2*n] | n_found[2*n+1];
      if (n_found[2*n] && (!n_found[2*n+1] || (n_key[2*n] <= n_key[2*n+1]))) begin
        n_key[n] = n_key[2*n];
        n_idx[n] = n_idx[2*n];
      end else begin
        n_key[n] = n_key[2*n+1];
        n_idx[n] = n_idx[2*n+1];
      end
    end
    sel.found = n_found[1];
    sel.idx   = n_idx[1];
  end

endmodule

// ===== sv/size_class_free_block_cache.sv =====
`timescale 1ns / 1ps
// Top level of the size-class free block cache: sequencer, row memory and
// hit counter. Depends on scfbc_pkg, scfbc_ram and scfbc_row_sel.
//
// A command beat is taken at a rising edge where start is high and busy is
// low; in_func selects get best fit, add block, clear block or reset table.
// Every command gives exactly one result beat: out_valid is high for one
// cycle with out_ok, out_found_addr, out_found_size and out_hit_count, and
// the receiver must take it then, as it cannot stall the block.
// The table lives in a memory of eleven rows, one per size class; the
// compare unit examines one whole row per cycle, one memory read each.
// Reset table, and add or clear of size zero, answer straight from idle; add
// and clear read their class row once in the scan state; get reads its own
// class row and then each larger one in turn until a fit, up to eleven rows.
// Busy stays high until the result is registered, so one command runs at a
// time; a new command may be given in the cycle its predecessor's result is
// shown. Reset empties every row at once through per-row valid flags and
// clears the hit counter; no clearing pass is needed.
module size_class_free_block_cache import scfbc_pkg::*; #(
  parameter int SLOTS_PER_CLASS = SLOTS_PER_CLASS_DEF,
  parameter int ADDR_BITS       = ADDR_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           in_func,
  input  logic [ADDR_BITS-1:0] in_block_addr,
  input  logic [REQ_W-1:0]     in_block_size,
  output logic                 out_valid,
  output logic                 out_ok,
  output logic [ADDR_BITS-1:0] out_found_addr,
  output logic [SIZE_W-1:0]    out_found_size,
  output logic [HIT_W-1:0]     out_hit_count
);

  localparam int SLOT_W = 1 + ADDR_BITS + SIZE_W;
  localparam int ROW_W  = SLOTS_PER_CLASS * SLOT_W;
  localparam int IDX_W  = (SLOTS_PER_CLASS > 1) ? $clog2(SLOTS_PER_CLASS) : 1;
  localparam logic [CLASS_W-1:0] LAST_CLASS = CLASS_W'(NUM_CLASSES - 1);

  state_t                 state_r, state_nxt;
  func_t                  func_r, func_nxt;
  logic [ADDR_BITS-1:0]   addr_r, addr_nxt;
  logic [REQ_W-1:0]       req_r, req_nxt;
  logic [CLASS_W-1:0]     cls_r, cls_nxt;
  logic [NUM_CLASSES-1:0] row_init_r, row_init_nxt;
  logic [HIT_W-1:0]       hit_r, hit_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_ok_r, out_ok_nxt;
  logic [ADDR_BITS-1:0]   out_addr_r, out_addr_nxt;
  logic [SIZE_W-1:0]      out_size_r, out_size_nxt;
  logic [HIT_W-1:0]       out_hit_r, out_hit_nxt;

  func_t                  fn_in;
  logic [CLASS_W-1:0]     cls_in;
  logic                   ram_we;
  logic [CLASS_W-1:0]     ram_raddr;
  logic [ROW_W-1:0]       ram_rdata;
  logic [ROW_W-1:0]       ram_wdata;
  logic [SLOTS_PER_CLASS-1:0] row_valid;
  logic [ADDR_BITS-1:0]   row_addr [SLOTS_PER_CLASS];
  logic [SIZE_W-1:0]      row_size [SLOTS_PER_CLASS];
  sel_t                   sel;
  logic [IDX_W-1:0]       sel_idx;

  assign fn_in  = func_t'(in_func);
  assign cls_in = size_class((fn_in == FN_GET) ? in_block_size
                                               : {1'b0, in_block_size[SIZE_W-1:0]});
  assign sel_idx = sel.idx[IDX_W-1:0];

  scfbc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_CLASSES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cls_r),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    for (int i = 0; i < SLOTS_PER_CLASS; i++) begin
      row_valid[i] = ram_rdata[i*SLOT_W + SLOT_W - 1] & row_init_r[cls_r];
      row_addr[i]  = ram_rdata[i*SLOT_W + SIZE_W +: ADDR_BITS];
      row_size[i]  = ram_rdata[i*SLOT_W +: SIZE_W];
    end
  end

  scfbc_row_sel #(
    .SLOTS     (SLOTS_PER_CLASS),
    .ADDR_BITS (ADDR_BITS)
  ) u_row_sel (
    .func      (func_r),
    .valid     (row_valid),
    .slot_addr (row_addr),
    .slot_size (row_size),
    .req       (req_r),
    .addr      (addr_r),
    .sel       (sel)
  );

  always_comb begin
    for (int i = 0; i < SLOTS_PER_CLASS; i++) begin
      if (IDX_W'(i) == sel_idx) begin
        if (func_r == FN_ADD) begin
          ram_wdata[i*SLOT_W +: SLOT_W] = {1'b1, addr_r, req_r[SIZE_W-1:0]};
        end else begin
          ram_wdata[i*SLOT_W +: SLOT_W] = {1'b0, row_addr[i], row_size[i]};
        end
      end else begin
        ram_wdata[i*SLOT_W +: SLOT_W] = {row_valid[i], row_addr[i], row_size[i]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      row_init_r  <= '0;
      hit_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_init_r  <= row_init_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    addr_r     <= addr_nxt;
    req_r      <= req_nxt;
    cls_r      <= cls_nxt;
    out_ok_r   <= out_ok_nxt;
    out_addr_r <= out_addr_nxt;
    out_size_r <= out_size_nxt;
    out_hit_r  <= out_hit_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    func_nxt      = func_r;
    addr_nxt      = addr_r;
    req_nxt       = req_r;
    cls_nxt       = cls_r;
    row_init_nxt  = row_init_r;
    hit_nxt       = hit_r;
    out_valid_nxt = 1'b0;
    out_ok_nxt    = out_ok_r;
    out_addr_nxt  = out_addr_r;
    out_size_nxt  = out_size_r;
    out_hit_nxt   = out_hit_r;
    ram_we        = 1'b0;
    ram_raddr     = cls_in;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          func_nxt = fn_in;
          addr_nxt = in_block_addr;
          req_nxt  = in_block_size;
          cls_nxt  = cls_in;
          unique case (fn_in) inside
            FN_RESET: begin
              row_init_nxt  = '0;
              hit_nxt       = '0;
              out_valid_nxt = 1'b1;
              out_ok_nxt    = 1'b1;
              out_addr_nxt  = '0;
              out_size_nxt  = '0;
              out_hit_nxt   = '0;
            end
            FN_ADD, FN_CLEAR: begin
              if (in_block_size[SIZE_W-1:0] == '0) begin
                out_valid_nxt = 1'b1;
                out_ok_nxt    = 1'b0;
                out_addr_nxt  = '0;
                out_size_nxt  = '0;
                out_hit_nxt   = hit_r;
              end else begin
                state_nxt = ST_SCAN;
              end
            end
            FN_GET: begin
              state_nxt = ST_SCAN;
            end
          endcase
        end
      end
      ST_SCAN: begin
        ram_raddr = (cls_r == LAST_CLASS) ? cls_r : cls_r + CLASS_W'(1);
        if (sel.found) begin
          ram_we        = 1'b1;
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          out_ok_nxt    = 1'b1;
          out_addr_nxt  = '0;
          out_size_nxt  = '0;
          if (func_r == FN_ADD) begin
            row_init_nxt[cls_r] = 1'b1;
          end
          if (func_r == FN_GET) begin
            hit_nxt      = hit_r + HIT_W'(1);
            out_addr_nxt = row_addr[sel_idx];
            out_size_nxt = row_size[sel_idx];
          end
          out_hit_nxt = hit_nxt;
        end else if ((func_r == FN_GET) && (cls_r != LAST_CLASS)) begin
          cls_nxt = cls_r + CLASS_W'(1);
        end else begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          out_ok_nxt    = 1'b0;
          out_addr_nxt  = '0;
          out_size_nxt  = '0;
          out_hit_nxt   = hit_r;
        end
      end
    endcase
  end

  assign busy           = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_ok         = out_ok_r;
  assign out_found_addr = out_addr_r;
  assign out_found_size = out_size_r;
  assign out_hit_count  = out_hit_r;

endmodule

// ===== sv/scfbc_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks of the free block cache, bound to the top level.
// Depends on scfbc_pkg and size_class_free_block_cache.
module scfbc_checker import scfbc_pkg::*; #(
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 start,
  input logic                 busy,
  input logic [1:0]           in_func,
  input logic                 out_valid,
  input logic                 out_ok,
  input logic [ADDR_BITS-1:0] out_found_addr,
  input logic [SIZE_W-1:0]    out_found_size,
  input logic [HIT_W-1:0]     out_hit_count
);

  // A table reset answers in the next cycle with success and a zero count.
  a_reset_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_func == FN_RESET))
      |=> (out_valid && out_ok && (out_hit_count == '0)))
    else $error("table reset did not answer at once with a cleared count");

  // A failed command never reports a block.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ok) |-> ((out_found_addr == '0) && (out_found_size == '0)))
    else $error("failed command reported a block");

  // A result beat is only shown once the block has finished its command.
  a_idle_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result beat shown while busy");

  // When the block turns busy, no result beat is shown in that cycle.
  a_busy_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> !out_valid)
    else $error("result beat shown as a scan began");

endmodule

bind size_class_free_block_cache scfbc_checker #(
  .ADDR_BITS (ADDR_BITS)
) u_scfbc_checker (.*);

// ===== bench/size_class_free_block_cache_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for size_class_free_block_cache: directed and random command beats,
// each predicted by a free block table mirror and checked against the result port.
// Depends on scfbc_pkg and the block's RTL.
module size_class_free_block_cache_tb;
  import scfbc_pkg::*;

  localparam int SLOTS = SLOTS_PER_CLASS_DEF;

  typedef struct packed {
    logic              ok;
    logic [SIZE_W-1:0] addr;
    logic [SIZE_W-1:0] words;
    logic [HIT_W-1:0]  hits;
  } cache_reply_t;

  class cache_mirror;
    bit              live      [NUM_CLASSES][SLOTS];
    bit [SIZE_W-1:0] base_addr [NUM_CLASSES][SLOTS];
    bit [SIZE_W-1:0] words     [NUM_CLASSES][SLOTS];
    bit [HIT_W-1:0]  hits;
    cache_reply_t    awaited [$];
    int              errors;

    // There is deliberately no class boundary at 2048 words.
    static function int class_of(bit [REQ_W-1:0] s);
      if (s < 8) return 0;
      if (s < 16) return 1;
      if (s < 32) return 2;
      if (s < 64) return 3;
      if (s < 128) return 4;
      if (s < 256) return 5;
      if (s < 512) return 6;
      if (s < 1024) return 7;
      if (s < 4096) return 8;
      if (s < 8192) return 9;
      return 10;
    endfunction

    function void note_command(func_t f, bit [SIZE_W-1:0] a, bit [REQ_W-1:0] req);
      cache_reply_t    r;
      bit [SIZE_W-1:0] hsize;
      int              best;
      bit [REQ_W-1:0]  best_words;
      bit              done;
      r = '0;
      hsize = req[SIZE_W-1:0];
      done = 1'b0;
      case (f)
        FN_GET: begin
          for (int c = class_of(req); c < NUM_CLASSES && !r.ok; c++) begin
            best = -1;
            best_words = 25'h100_0000;
            for (int s = 0; s < SLOTS; s++) begin
              if (live[c][s] && {1'b0, words[c][s]} < best_words &&
                  {1'b0, words[c][s]} >= req) begin
                best = s;
                best_words = {1'b0, words[c][s]};
              end
            end
            if (best >= 0) begin
              r.ok = 1'b1;
              r.addr = base_addr[c][best];
              r.words = words[c][best];
              live[c][best] = 1'b0;
              hits++;
            end
          end
        end
        FN_ADD: begin
          if (hsize != 0) begin
            for (int s = 0; s < SLOTS && !done; s++) begin
              if (!live[class_of({1'b0, hsize})][s] ||
                  words[class_of({1'b0, hsize})][s] < hsize) begin
                live[class_of({1'b0, hsize})][s] = 1'b1;
                base_addr[class_of({1'b0, hsize})][s] = a;
                words[class_of({1'b0, hsize})][s] = hsize;
                done = 1'b1;
              end
            end
          end
          r.ok = done;
        end
        FN_CLEAR: begin
          if (hsize != 0) begin
            for (int s = 0; s < SLOTS && !done; s++) begin
              if (live[class_of({1'b0, hsize})][s] &&
                  base_addr[class_of({1'b0, hsize})][s] == a) begin
                live[class_of({1'b0, hsize})][s] = 1'b0;
                done = 1'b1;
              end
            end
          end
          r.ok = done;
        end
        default: begin
          foreach (live[c, s]) live[c][s] = 1'b0;
          hits = '0;
          r.ok = 1'b1;
        end
      endcase
      r.hits = hits;
      awaited.push_back(r);
    endfunction

    function void compare(string field, logic [HIT_W-1:0] want, logic [HIT_W-1:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t ns: %s expected %h actual %h", $time, field, want, got);
      end
    endfunction

    function void check_result(cache_reply_t got);
      cache_reply_t want;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t ns: result beat expected none actual %h", $time, got);
        return;
      end
      want = awaited.pop_front();
      compare("ok", HIT_W'(want.ok), HIT_W'(got.ok));
      compare("found_addr", HIT_W'(want.addr), HIT_W'(got.addr));
      compare("found_size", HIT_W'(want.words), HIT_W'(got.words));
      compare("hit_count", want.hits, got.hits);
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [1:0]          in_func = FN_GET;
  logic [SIZE_W-1:0]   in_block_addr = '0;
  logic [REQ_W-1:0]    in_block_size = '0;
  logic                out_valid;
  logic                out_ok;
  logic [SIZE_W-1:0]   out_found_addr;
  logic [SIZE_W-1:0]   out_found_size;
  logic [HIT_W-1:0]    out_hit_count;

  cache_mirror mirror;
  int          idle_pct = 0;
  int          burst_left = 0;
  int          burst_class = 0;

  always #5 clk = ~clk;

  size_class_free_block_cache dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_func        (in_func),
    .in_block_addr  (in_block_addr),
    .in_block_size  (in_block_size),
    .out_valid      (out_valid),
    .out_ok         (out_ok),
    .out_found_addr (out_found_addr),
    .out_found_size (out_found_size),
    .out_hit_count  (out_hit_count)
  );

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      mirror.check_result({out_ok, out_found_addr, out_found_size, out_hit_count});
    end
  end

  function automatic bit [REQ_W-1:0] class_floor(int c);
    if (c == 0) return '0;
    if (c <= 8) return REQ_W'(8 << (c - 1));
    if (c == 9) return 25'd4096;
    return 25'd8192;
  endfunction

  function automatic bit [REQ_W-1:0] size_in_class(int c);
    int unsigned lo;
    int unsigned hi;
    lo = (c == 0) ? 32'd1 : 32'(class_floor(c));
    hi = (c == NUM_CLASSES - 1) ? 32'hFF_FFFF : 32'(class_floor(c + 1)) - 32'd1;
    return REQ_W'($urandom_range(hi, lo));
  endfunction

  function automatic bit [REQ_W-1:0] pick_size();
    int roll;
    int w;
    roll = $urandom_range(9, 0);
    if (roll < 5) return size_in_class($urandom_range(3, 0));
    if (roll < 8) return size_in_class($urandom_range(NUM_CLASSES - 1, 0));
    w = $urandom_range(25, 0);
    if (w == 25) return 25'h100_0000;
    return REQ_W'($urandom & ((32'd1 << w) - 1));
  endfunction

  task automatic issue(func_t f, bit [SIZE_W-1:0] a, bit [REQ_W-1:0] s);
    @(negedge clk);
    while ($urandom_range(99, 0) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_func <= f;
    in_block_addr <= a;
    in_block_size <= s;
    do @(posedge clk); while (busy !== 1'b0);
    mirror.note_command(f, a, s);
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (mirror.awaited.size() != 0) @(posedge clk);
  endtask

  task automatic random_command();
    func_t           f;
    bit [SIZE_W-1:0] a;
    bit [REQ_W-1:0]  s;
    int              roll;
    int              k;
    int              picks [$];
    a = SIZE_W'($urandom);
    s = pick_size();
    if (burst_left > 0) begin
      burst_left--;
      f = FN_ADD;
      s = size_in_class(burst_class);
    end else begin
      roll = $urandom_range(199, 0);
      if (roll < 2) begin
        f = FN_RESET;
      end else if (roll < 6) begin
        f = FN_ADD;
        burst_left = $urandom_range(40, 20);
        burst_class = $urandom_range(NUM_CLASSES - 1, 0);
        s = size_in_class(burst_class);
      end else if (roll < 76) begin
        f = FN_GET;
      end else if (roll < 106) begin
        f = FN_CLEAR;
      end else begin
        f = FN_ADD;
      end
    end
    if ((f == FN_CLEAR && $urandom_range(3, 0) != 0) ||
        (f == FN_ADD && $urandom_range(9, 0) == 0)) begin
      for (int i = 0; i < NUM_CLASSES * SLOTS; i++) begin
        if (mirror.live[i / SLOTS][i % SLOTS]) picks.push_back(i);
      end
      if (picks.size() > 0) begin
        k = picks[$urandom_range(picks.size() - 1, 0)];
        a = mirror.base_addr[k / SLOTS][k % SLOTS];
        if (f == FN_CLEAR) s = size_in_class(k / SLOTS);
      end
    end
    issue(f, a, s);
  endtask

  task automatic random_phase(int pct, int count);
    idle_pct = pct;
    repeat (count) begin
      if ($urandom_range(59, 0) == 0) drain();
      random_command();
    end
    drain();
  endtask

  initial begin
    mirror = new();
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    issue(FN_GET, 24'h000000, 25'd5);
    issue(FN_ADD, 24'h000123, 25'd0);
    issue(FN_ADD, 24'h000124, 25'h100_0000);
    issue(FN_CLEAR, 24'h000000, 25'd0);
    issue(FN_ADD, 24'h000000, 25'd1);
    issue(FN_ADD, 24'hFFFFFF, 25'hFF_FFFF);
    issue(FN_ADD, 24'h000800, 25'd2048);
    issue(FN_ADD, 24'h000801, 25'd4095);
    issue(FN_ADD, 24'h001000, 25'd4096);
    issue(FN_ADD, 24'h002000, 25'd8191);
    issue(FN_ADD, 24'h004000, 25'd8192);
    issue(FN_ADD, 24'h555555, 25'd7);
    issue(FN_ADD, 24'h555555, 25'd7);
    issue(FN_GET, 24'h000000, 25'd0);
    issue(FN_GET, 24'h000000, 25'h100_0000);
    issue(FN_GET, 24'h000000, 25'd3000);
    issue(FN_ADD, 24'h000000, 25'd3);
    issue(FN_CLEAR, 24'h000000, 25'd6);
    issue(FN_CLEAR, 24'h555555, 25'd3);
    issue(FN_CLEAR, 24'h123456, 25'd3);
    issue(FN_GET, 24'h000000, 25'hFF_FFFF);
    issue(FN_GET, 24'h000000, 25'd8);
    issue(FN_RESET, 24'hAAAAAA, 25'h155_5555 & 25'hFF_FFFF);
    issue(FN_GET, 24'h000000, 25'd1);
    issue(FN_CLEAR, 24'hFFFFFF, 25'hFF_FFFF);
    drain();

    random_phase(34, 580);
    random_phase(88, 580);
    random_phase(0, 590);

    repeat (20) @(posedge clk);
    if (mirror.errors == 0 && mirror.awaited.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
